[rtl/core/rpt_pkg.sv]
// ----------------------------------------------------------------------------
// rpt_pkg
// Types, register indexes and the constant base-2 log table of the
// RGB point transform.
// ----------------------------------------------------------------------------
package rpt_pkg;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } pixel_out_type;

   typedef enum logic [1:0] {
      REG_MODE      = 2'd0,
      REG_LOG_GAIN  = 2'd1,
      REG_GAMMA_EXP = 2'd2,
      REG_NONE      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_GRAY   = 2'd0,
      MODE_INVERT = 2'd1,
      MODE_LOG    = 2'd2,
      MODE_POWER  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_READY,
      ST_MUL1,
      ST_MUL2,
      ST_SEARCH,
      ST_WRITE
   } fill_state_type;

   localparam logic [1:0]  MODE_RESET      = 2'd0;
   localparam logic [15:0] LOG_GAIN_RESET  = 16'd11774;
   localparam logic [15:0] GAMMA_EXP_RESET = 16'd4096;
   localparam logic [31:0] LN2_Q32         = 32'd2977044471;
   localparam int          FRAC_BITS       = 28;
   localparam int          ROM_DEPTH       = 257;

   typedef logic [31:0] log_rom_type [ROM_DEPTH];

   // log2 in Q28 by repeated squaring of the normalized mantissa
   function automatic logic [31:0] fixed_log2(input int unsigned x);
      int unsigned n;
      int unsigned t;
      logic [63:0] m;
      logic [31:0] frac;
      n = 0;
      t = x;
      while (t > 1) begin
         t = t >> 1;
         n++;
      end
      m = 64'(x) << (30 - n);
      frac = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         m = (m * m) >> 30;
         frac = {frac[30:0], 1'b0};
         if (m >= (64'd2 << 30)) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (32'(n) << FRAC_BITS) | frac;
   endfunction

   function automatic log_rom_type build_log_rom();
      log_rom_type rom;
      rom[0] = '0;
      for (int k = 1; k < ROM_DEPTH; k++) begin
         rom[k] = fixed_log2(k);
      end
      return rom;
   endfunction

   localparam log_rom_type LOG_ROM = build_log_rom();
   localparam logic [31:0] LOG_TOP = LOG_ROM[255];

endpackage

[rtl/core/rgb_point_transform_top.sv]
// ----------------------------------------------------------------------------
// rgb_point_transform_top
// Per-pixel point transform (grayscale, invert, log, power) of 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one pixel word per accepted cycle (req_valid high, req_stall low).
//  - rsp_*: one transformed pixel word per input word, in order.
//  - csr_*: register writes (index 0 mode, 1 log_gain, 2 gamma_exp); csr_ready
//    is always high, other indexes are dropped.
//  - log and power channels come from a 256-entry mapping memory (one copy per
//    channel) that a fill engine rebuilds for the current mode and settings.
//    A rebuild starts after reset and after every register write and runs one
//    multiply/search sequence per entry; req_stall stays high while it runs.
//  - an accepted word goes through the read stage, then the output register.
//  - throughput: one pixel per cycle while req_stall is low, set by the single
//    read port of each memory copy, which is read once per pixel.
//  - when the receiver stalls, the output word holds, one more word waits in
//    the read stage, and then req_stall rises.
// ----------------------------------------------------------------------------
module rgb_point_transform_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rpt_pkg::pixel_in_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rpt_pkg::pixel_out_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import rpt_pkg::*;

   logic [1:0]  mode_ff;
   logic [15:0] gain_ff;
   logic [15:0] gamma_ff;
   logic        csr_wr;

   fill_state_type state_ff, state_in;
   logic [7:0]  fill_v_ff;
   logic [63:0] prod_a_ff;
   logic [47:0] prod_e_ff;
   logic [7:0]  log_ff;
   logic [7:0]  res_ff;
   logic [2:0]  bit_ff;
   logic        building;
   logic        lut_we;
   logic [7:0]  lut_wdata;

   logic [7:0]  lut_r [256];
   logic [7:0]  lut_g [256];
   logic [7:0]  lut_b [256];

   logic        accept;
   logic        s1_valid_ff;
   logic        s1_adv;
   pixel_in_type s1_pix_ff;
   logic [1:0]  s1_mode_ff;
   logic [7:0]  s1_gray_ff;
   logic [7:0]  rd_r_ff, rd_g_ff, rd_b_ff;
   logic        out_valid_ff;
   pixel_out_type out_ff;

   logic [9:0]  sum;
   logic [19:0] gray_prod;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         gain_ff  <= LOG_GAIN_RESET;
         gamma_ff <= GAMMA_EXP_RESET;
      end else if (csr_wr) begin
         unique case (csr_index_type'(csr_index))
            REG_MODE:      mode_ff  <= csr_data[1:0];
            REG_LOG_GAIN:  gain_ff  <= csr_data;
            REG_GAMMA_EXP: gamma_ff <= csr_data;
            REG_NONE: ;
            default: ;
         endcase
      end
   end

   // ---------------- fill engine ----------------
   logic [8:0]  next_idx;
   logic [31:0] log_v1;
   logic [31:0] log_v;
   logic [31:0] log_span;
   logic [7:0]  cand;
   logic [36:0] cand_sum;
   logic [47:0] gain_prod;
   logic [11:0] log_raw;

   assign next_idx  = {1'b0, fill_v_ff} + 9'd1;
   assign log_v1    = LOG_ROM[next_idx];
   assign log_v     = LOG_ROM[{1'b0, fill_v_ff}];
   assign log_span  = LOG_TOP - log_v;
   assign cand      = res_ff | (8'd1 << bit_ff);
   assign cand_sum  = {5'd0, LOG_ROM[{1'b0, cand}]} + {1'b0, prod_e_ff[47:12]};
   assign gain_prod = 48'(gain_ff) * 48'(prod_a_ff[63:32]);
   assign log_raw   = gain_prod[47:36];

   always_comb begin
      state_in = state_ff;
      if (csr_wr) begin
         state_in = ST_MUL1;
      end else begin
         unique case (state_ff)
            ST_READY:  state_in = ST_READY;
            ST_MUL1:   state_in = ST_MUL2;
            ST_MUL2:   state_in = ST_SEARCH;
            ST_SEARCH: state_in = (bit_ff == 3'd0) ? ST_WRITE : ST_SEARCH;
            ST_WRITE:  state_in = (fill_v_ff == 8'hFF) ? ST_READY : ST_MUL1;
            default:   state_in = ST_MUL1;
         endcase
      end
   end

   always_comb begin
      building = (state_ff != ST_READY);
      lut_we   = (state_ff == ST_WRITE);
      priority if (mode_ff == MODE_LOG) begin
         lut_wdata = log_ff;
      end else if (gamma_ff == 16'd0) begin
         lut_wdata = 8'hFF;
      end else if (fill_v_ff == 8'd0) begin
         lut_wdata = 8'd0;
      end else begin
         lut_wdata = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_MUL1;
         fill_v_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            fill_v_ff <= '0;
         end else if (state_ff == ST_WRITE) begin
            fill_v_ff <= fill_v_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_MUL1: begin
            prod_a_ff <= 64'(log_v1) * 64'(LN2_Q32);
            prod_e_ff <= 48'(gamma_ff) * 48'(log_span);
         end
         ST_MUL2: begin
            log_ff <= (log_raw > 12'd255) ? 8'hFF : log_raw[7:0];
            res_ff <= '0;
            bit_ff <= 3'd7;
         end
         ST_SEARCH: begin
            if (cand_sum <= {5'd0, LOG_TOP}) begin
               res_ff <= cand;
            end
            bit_ff <= bit_ff - 3'd1;
         end
         ST_READY, ST_WRITE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lut_we) begin
         lut_r[fill_v_ff] <= lut_wdata;
         lut_g[fill_v_ff] <= lut_wdata;
         lut_b[fill_v_ff] <= lut_wdata;
      end
   end

   // ---------------- pixel pipeline ----------------
   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = building || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   assign sum       = 10'(req_data.red_in) + 10'(req_data.green_in)
                    + 10'(req_data.blue_in);
   // divide by 3 via reciprocal, exact for sums up to 765
   assign gray_prod = 20'(sum) * 20'd683;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_r_ff    <= lut_r[req_data.red_in];
         rd_g_ff    <= lut_g[req_data.green_in];
         rd_b_ff    <= lut_b[req_data.blue_in];
         s1_pix_ff  <= req_data;
         s1_mode_ff <= mode_ff;
         s1_gray_ff <= gray_prod[18:11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         unique case (mode_type'(s1_mode_ff))
            MODE_GRAY: begin
               out_ff.red_out   <= s1_gray_ff;
               out_ff.green_out <= s1_gray_ff;
               out_ff.blue_out  <= s1_gray_ff;
            end
            MODE_INVERT: begin
               out_ff.red_out   <= ~s1_pix_ff.red_in;
               out_ff.green_out <= ~s1_pix_ff.green_in;
               out_ff.blue_out  <= ~s1_pix_ff.blue_in;
            end
            MODE_LOG, MODE_POWER: begin
               out_ff.red_out   <= rd_r_ff;
               out_ff.green_out <= rd_g_ff;
               out_ff.blue_out  <= rd_b_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_no_accept_while_fill: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_READY))
      else $error("pixel word accepted during memory fill");

   a_write_restarts_fill: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (state_ff == ST_MUL1 && fill_v_ff == 8'd0))
      else $error("register write did not restart the fill");

   a_fill_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && !csr_wr && fill_v_ff != 8'hFF)
      |=> (fill_v_ff == $past(fill_v_ff) + 8'd1 && state_ff == ST_MUL1))
      else $error("fill address did not advance");

   a_s1_no_loss: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("read stage word dropped");
`endif

endmodule

[bench/rpt_checker.sv]
// ----------------------------------------------------------------------------
// rpt_checker
// Watches the pixel, result and register channels of the RGB point transform.
// It predicts every result word from the accepted pixel and the current
// settings, and compares it field by field with the word that comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rpt_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  rpt_pkg::pixel_in_type  req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rpt_pkg::pixel_out_type rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output int                     mismatches,
   output int                     pending
);
   import rpt_pkg::*;

   logic [31:0]   lg2_q28 [257];
   mode_type      cur_mode;
   logic [15:0]   cur_gain;
   logic [15:0]   cur_gamma;
   pixel_out_type pixels_due [$];

   // base-2 log in Q28: square the normalized mantissa once per fraction bit
   function automatic logic [31:0] lg2_of(int unsigned x);
      int unsigned ipart;
      int unsigned t;
      logic [63:0] man;
      logic [31:0] fbits;
      ipart = 0;
      t = x;
      fbits = '0;
      while (t > 1) begin
         t = t >> 1;
         ipart++;
      end
      man = 64'(x) << (30 - ipart);
      for (int i = 0; i < 28; i++) begin
         man = (man * man) >> 30;
         fbits = fbits << 1;
         if (man >= (64'd1 << 31)) begin
            fbits[0] = 1'b1;
            man = man >> 1;
         end
      end
      return (32'(ipart) << 28) | fbits;
   endfunction

   function automatic logic [7:0] log_map(logic [7:0] v);
      logic [63:0] q;
      logic [63:0] r;
      q = (64'(lg2_q28[v + 1]) * 64'd2977044471) >> 32;
      r = (64'(cur_gain) * q) >> 36;
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   function automatic logic [7:0] power_map(logic [7:0] v);
      logic [63:0] e;
      int unsigned cnt;
      if (cur_gamma == 0) return 8'd255;
      if (v == 0) return 8'd0;
      e = (64'(cur_gamma) * 64'(lg2_q28[255] - lg2_q28[v])) >> 12;
      cnt = 0;
      for (int y = 1; y <= 255; y++) begin
         if (64'(lg2_q28[y]) + e <= 64'(lg2_q28[255])) cnt++;
      end
      return 8'(cnt);
   endfunction

   function automatic logic [7:0] chan_map(logic [7:0] v);
      case (cur_mode)
         MODE_INVERT: return 8'd255 - v;
         MODE_LOG:    return log_map(v);
         default:     return power_map(v);
      endcase
   endfunction

   function automatic pixel_out_type transform_pixel(pixel_in_type p);
      pixel_out_type o;
      logic [9:0] sum;
      if (cur_mode == MODE_GRAY) begin
         sum = 10'(p.red_in) + 10'(p.green_in) + 10'(p.blue_in);
         o.red_out   = 8'(sum / 3);
         o.green_out = o.red_out;
         o.blue_out  = o.red_out;
      end else begin
         o.red_out   = chan_map(p.red_in);
         o.green_out = chan_map(p.green_in);
         o.blue_out  = chan_map(p.blue_in);
      end
      return o;
   endfunction

   initial begin
      for (int k = 1; k < 257; k++) lg2_q28[k] = lg2_of(k);
      lg2_q28[0] = '0;
   end

   always @(posedge clock) begin
      pixel_out_type want;
      int            delta;
      delta = 0;
      if (reset) begin
         cur_mode   <= MODE_GRAY;
         cur_gain   <= 16'd11774;
         cur_gamma  <= 16'd4096;
         mismatches <= 0;
         pending    <= 0;
         pixels_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_MODE:      cur_mode  <= mode_type'(csr_data[1:0]);
               REG_LOG_GAIN:  cur_gain  <= csr_data;
               REG_GAMMA_EXP: cur_gamma <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pixels_due.push_back(transform_pixel(req_data));
            delta = delta + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixels_due.size() == 0) begin
               if (mismatches < 10) $display("%0t: unexpected word %h", $realtime, rsp_data);
               mismatches <= mismatches + 1;
            end else begin
               want = pixels_due.pop_front();
               delta = delta - 1;
               if (want.red_out !== rsp_data.red_out || want.green_out !== rsp_data.green_out
                   || want.blue_out !== rsp_data.blue_out) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch exp r%0d g%0d b%0d got r%0d g%0d b%0d",
                              $realtime, want.red_out, want.green_out, want.blue_out,
                              rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out);
                  mismatches <= mismatches + 1;
               end
            end
         end
         pending <= pending + delta;
      end
   end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the RGB point transform: directed corner pixels under every
// mode and extreme setting, then random phases of random settings and pixels
// with random gaps, random stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import rpt_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   pixel_in_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b1;
   pixel_out_type rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [15:0]   csr_data = '0;
   int            mismatches;
   int            pending;
   bit            no_gaps = 1'b0;
   bit            long_hold = 1'b0;
   bit            hold_done = 1'b0;
   int            quiet_cycles = 0;

   always #5 clock = ~clock;

   rgb_point_transform_top uut (.*);

   rpt_checker chk (.*);

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: stall for a random count before each word (none in gap-free phases), or one long hold-off
   initial begin
      int k;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold && !hold_done) begin
            // one long hold-off, so the block fills and stalls its input
            k = 400;
            hold_done = 1'b1;
         end else if (no_gaps) k = 0;
         else k = $urandom_range(0, 7);
         rsp_stall = (k > 0);
         repeat (k) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = '{red_in: r, green_in: g, blue_in: b};
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_all(mode_type m, logic [15:0] gain, logic [15:0] gam);
      write_reg(REG_MODE, 16'(m));
      write_reg(REG_LOG_GAIN, gain);
      write_reg(REG_GAMMA_EXP, gam);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom_range(1, 8192));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset settings: grayscale
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      set_all(MODE_INVERT, 16'd11774, 16'd4096);
      send_pixel(8'd0, 8'd255, 8'd128);
      send_pixel(8'd255, 8'd1, 8'd127);
      set_all(MODE_LOG, 16'hffff, 16'd4096);
      send_pixel(8'd0, 8'd255, 8'd1);
      send_pixel(8'd100, 8'd200, 8'd15);
      write_reg(REG_LOG_GAIN, 16'd0);
      send_pixel(8'd0, 8'd255, 8'd77);
      set_all(MODE_POWER, 16'd11774, 16'd0);
      // zero gamma maps everything to full scale
      send_pixel(8'd0, 8'd255, 8'd1);
      write_reg(REG_GAMMA_EXP, 16'hffff);
      send_pixel(8'd0, 8'd255, 8'd254);
      send_pixel(8'd1, 8'd128, 8'd200);
      write_reg(REG_GAMMA_EXP, 16'd1);
      send_pixel(8'd0, 8'd1, 8'd255);
      send_pixel(8'd2, 8'd128, 8'd254);
      write_reg(REG_GAMMA_EXP, 16'd4096);
      send_pixel(8'd0, 8'd1, 8'd255);
      write_reg(REG_NONE, 16'hffff);
      send_pixel(8'd3, 8'd30, 8'd250);

      for (int ph = 0; ph < 14; ph++) begin
         set_all(mode_type'($urandom_range(0, 3)), pick16(), pick16());
         no_gaps = (ph % 4 == 1);
         // the result side takes up the long hold-off on its next word
         if (ph == 3) long_hold = 1'b1;
         for (int i = 0; i < 130; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         no_gaps = 1'b0;
         long_hold = 1'b0;
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
